>>> rtl/core/ihex_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, result codes and the hex digit decoder of the Intel HEX parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

  typedef logic [7:0]  char_t;
  typedef logic [1:0]  kind_t;
  typedef logic [15:0] addr_t;
  typedef logic [7:0]  byte_t;
  typedef logic [3:0]  status_t;

  // result kinds
  localparam kind_t KIND_DATA  = 2'd0;
  localparam kind_t KIND_DONE  = 2'd1;
  localparam kind_t KIND_BLANK = 2'd2;

  // record status codes
  localparam status_t ST_OK        = 4'd0;
  localparam status_t ST_END       = 4'd1;
  localparam status_t ST_LENGTH    = 4'd2;
  localparam status_t ST_ADDRESS   = 4'd3;
  localparam status_t ST_TYPE      = 4'd4;
  localparam status_t ST_UNSUPP    = 4'd5;
  localparam status_t ST_DATA      = 4'd6;
  localparam status_t ST_CK_MISS   = 4'd7;
  localparam status_t ST_MISMATCH  = 4'd8;
  localparam status_t ST_NO_EOL    = 4'd9;

  localparam char_t CHAR_COLON = 8'h3A;
  localparam char_t CHAR_CR    = 8'h0D;
  localparam char_t CHAR_LF    = 8'h0A;
  localparam byte_t END_CK     = 8'hFF;

  // {valid, value} of an ASCII hex digit
  function automatic logic [4:0] hex_decode(input char_t c);
    logic [4:0] res;
    begin
      res = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
        res = {1'b1, c[3:0]};
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
        res = {1'b1, c[3:0] + 4'd9};
      end
      return res;
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/ihex_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ihex_if
// Valid/ready channels of the Intel HEX parser: character in, result out.
// ----------------------------------------------------------------------------
interface ihex_in_if;
  import ihex_pkg::*;
  logic  valid;
  logic  ready;
  char_t char_code;
  logic  end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface ihex_out_if;
  import ihex_pkg::*;
  logic    valid;
  logic    ready;
  kind_t   kind;
  addr_t   address;
  byte_t   data_byte;
  status_t status;

  modport source (output valid, output kind, output address, output data_byte,
                  output status, input ready);
  modport sink   (input valid, input kind, input address, input data_byte,
                  input status, output ready);
endinterface
`default_nettype wire

>>> rtl/core/intel_hex_record_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// intel_hex_record_parser_unit
// Character-at-a-time parser for Intel HEX data (00) and end (01) records.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one ASCII character per word, or an end-of-input mark.
//   out_ch : data byte with its address, record status, or blank-line ack.
//   A word is taken when valid and ready are both high.
// Each character is decoded in the cycle it is taken; the parser state and
// the result register update at that edge, so a result is visible on out_ch
// in the cycle after its character is accepted. One character per cycle is
// sustained unless out_ch stalls; the single output register sets that figure.
// in_ch.ready is high while the output register is empty or being drained,
// so a stalled receiver holds at most one result and then back-pressures.
// Data bytes of a record leave as they are decoded; the closing status word
// tells the receiver to commit (status ok) or drop them.
// After an error or an end record the parser swallows all further input
// without results until rst_n (synchronous, active low) is asserted.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_unit (
  input  wire clk,
  input  wire rst_n,
  ihex_in_if.sink    in_ch,
  ihex_out_if.source out_ch
);
  import ihex_pkg::*;

  localparam logic [3:0] PH_SEARCH  = 4'd0;
  localparam logic [3:0] PH_LEN     = 4'd1;
  localparam logic [3:0] PH_ADDR_HI = 4'd2;
  localparam logic [3:0] PH_ADDR_LO = 4'd3;
  localparam logic [3:0] PH_TYPE    = 4'd4;
  localparam logic [3:0] PH_DATA    = 4'd5;
  localparam logic [3:0] PH_CKSUM   = 4'd6;
  localparam logic [3:0] PH_END_CK  = 4'd7;
  localparam logic [3:0] PH_LINE    = 4'd8;
  localparam logic [3:0] PH_LINE_LF = 4'd9;

  logic [3:0] phase_r, phase_nxt;
  logic       second_r, second_nxt;
  logic [3:0] high_nib_r, high_nib_nxt;
  byte_t      rec_len_r, rec_len_nxt;
  addr_t      rec_addr_r, rec_addr_nxt;
  logic       rec_type_r, rec_type_nxt;
  byte_t      left_r, left_nxt;
  byte_t      sum_r, sum_nxt;
  logic       halted_r, halted_nxt;

  logic    out_valid_r;
  kind_t   kind_r;
  addr_t   addr_r;
  byte_t   data_r;
  status_t status_r;

  logic    res_vld;
  kind_t   res_kind;
  addr_t   res_addr;
  byte_t   res_data;
  status_t res_status;

  logic       in_accept;
  logic [4:0] hex;
  logic       nib_ok;
  byte_t      byte_val;
  byte_t      sum_add;
  byte_t      offset;
  byte_t      left_dec;
  status_t    dig_err;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign hex      = hex_decode(in_ch.char_code);
  assign nib_ok   = hex[4] && !in_ch.end_of_input;
  assign byte_val = {high_nib_r, hex[3:0]};
  assign sum_add  = sum_r + byte_val;
  assign offset   = rec_len_r - left_r;
  assign left_dec = left_r - 8'd1;

  always_comb begin
    case (phase_r)
      PH_LEN:                dig_err = ST_LENGTH;
      PH_ADDR_HI, PH_ADDR_LO: dig_err = ST_ADDRESS;
      PH_TYPE:               dig_err = ST_TYPE;
      PH_DATA:               dig_err = ST_DATA;
      PH_CKSUM:              dig_err = ST_CK_MISS;
      default:               dig_err = ST_MISMATCH;
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    second_nxt   = second_r;
    high_nib_nxt = high_nib_r;
    rec_len_nxt  = rec_len_r;
    rec_addr_nxt = rec_addr_r;
    rec_type_nxt = rec_type_r;
    left_nxt     = left_r;
    sum_nxt      = sum_r;
    halted_nxt   = halted_r;
    res_vld      = 1'b0;
    res_kind     = KIND_DATA;
    res_addr     = '0;
    res_data     = '0;
    res_status   = ST_OK;

    if (!halted_r) begin
      if (phase_r == PH_LINE || phase_r == PH_LINE_LF) begin
        if (!in_ch.end_of_input && in_ch.char_code == CHAR_LF) begin
          phase_nxt = PH_SEARCH;
          res_vld   = 1'b1;
          res_kind  = KIND_DONE;
          if (rec_type_r) begin
            halted_nxt = 1'b1;
            res_status = ST_END;
          end
        end else if (!in_ch.end_of_input && in_ch.char_code == CHAR_CR &&
                     phase_r == PH_LINE) begin
          phase_nxt = PH_LINE_LF;
        end else begin
          phase_nxt  = PH_SEARCH;
          halted_nxt = 1'b1;
          res_vld    = 1'b1;
          res_kind   = KIND_DONE;
          res_status = ST_NO_EOL;
        end
      end else if (phase_r inside {[PH_LEN:PH_END_CK]}) begin
        if (!nib_ok) begin
          phase_nxt  = PH_SEARCH;
          halted_nxt = 1'b1;
          res_vld    = 1'b1;
          res_kind   = KIND_DONE;
          res_status = dig_err;
        end else if (!second_r) begin
          high_nib_nxt = hex[3:0];
          second_nxt   = 1'b1;
        end else begin
          second_nxt = 1'b0;
          sum_nxt    = sum_add;
          case (phase_r)
            PH_LEN: begin
              rec_len_nxt = byte_val;
              phase_nxt   = PH_ADDR_HI;
            end
            PH_ADDR_HI: begin
              rec_addr_nxt = {byte_val, 8'h00};
              phase_nxt    = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
              rec_addr_nxt = {rec_addr_r[15:8], byte_val};
              phase_nxt    = PH_TYPE;
            end
            PH_TYPE: begin
              if (byte_val == 8'h00) begin
                rec_type_nxt = 1'b0;
                left_nxt     = rec_len_r;
                phase_nxt    = (rec_len_r != 8'd0) ? PH_DATA : PH_CKSUM;
              end else if (byte_val == 8'h01) begin
                rec_type_nxt = 1'b1;
                phase_nxt    = PH_END_CK;
              end else begin
                phase_nxt  = PH_SEARCH;
                halted_nxt = 1'b1;
                res_vld    = 1'b1;
                res_kind   = KIND_DONE;
                res_status = ST_UNSUPP;
              end
            end
            PH_DATA: begin
              left_nxt = left_dec;
              if (left_dec == 8'd0) phase_nxt = PH_CKSUM;
              res_vld  = 1'b1;
              res_kind = KIND_DATA;
              res_addr = rec_addr_r + {8'h00, offset};
              res_data = byte_val;
            end
            PH_CKSUM: begin
              if (sum_add != 8'd0) begin
                phase_nxt  = PH_SEARCH;
                halted_nxt = 1'b1;
                res_vld    = 1'b1;
                res_kind   = KIND_DONE;
                res_status = ST_MISMATCH;
              end else begin
                phase_nxt = PH_LINE;
              end
            end
            default: begin
              // end record: checksum byte must be literally FF
              if (byte_val != END_CK) begin
                phase_nxt  = PH_SEARCH;
                halted_nxt = 1'b1;
                res_vld    = 1'b1;
                res_kind   = KIND_DONE;
                res_status = ST_MISMATCH;
              end else begin
                phase_nxt = PH_LINE;
              end
            end
          endcase
        end
      end else begin
        // searching, unused codes fold in here
        phase_nxt = PH_SEARCH;
        if (!in_ch.end_of_input) begin
          if (in_ch.char_code == CHAR_CR || in_ch.char_code == CHAR_LF) begin
            res_vld  = 1'b1;
            res_kind = KIND_BLANK;
          end else if (in_ch.char_code == CHAR_COLON) begin
            phase_nxt    = PH_LEN;
            second_nxt   = 1'b0;
            high_nib_nxt = 4'd0;
            sum_nxt      = 8'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SEARCH;
      second_r   <= 1'b0;
      high_nib_r <= 4'd0;
      rec_len_r  <= 8'd0;
      rec_addr_r <= 16'd0;
      rec_type_r <= 1'b0;
      left_r     <= 8'd0;
      sum_r      <= 8'd0;
      halted_r   <= 1'b0;
    end else if (in_accept) begin
      phase_r    <= phase_nxt;
      second_r   <= second_nxt;
      high_nib_r <= high_nib_nxt;
      rec_len_r  <= rec_len_nxt;
      rec_addr_r <= rec_addr_nxt;
      rec_type_r <= rec_type_nxt;
      left_r     <= left_nxt;
      sum_r      <= sum_nxt;
      halted_r   <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && res_vld) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_vld) begin
      kind_r   <= res_kind;
      addr_r   <= res_addr;
      data_r   <= res_data;
      status_r <= res_status;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = kind_r;
  assign out_ch.address   = addr_r;
  assign out_ch.data_byte = data_r;
  assign out_ch.status    = status_r;

endmodule
`default_nettype wire

>>> sim/tb_intel_hex_record_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_intel_hex_record_parser_unit
// Feeds Intel HEX text one character word at a time with random idles on both
// channels. A scoreboard parses the same stream and checks every result word.
// The run ends in one randomly chosen terminating record, then more input that
// must stay silent.
// ----------------------------------------------------------------------------
module tb_intel_hex_record_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ihex_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_CHARS = 450;

  typedef enum logic [3:0] {
    PH_HUNT, PH_LEN, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE,
    PH_DATA, PH_CK, PH_END_CK, PH_EOL, PH_EOL_LF
  } parse_phase_e;

  typedef enum int {
    TAIL_END_OK, TAIL_END_CK_VALUE, TAIL_END_CK_DIGIT, TAIL_LEN_DIGIT,
    TAIL_ADDR_DIGIT, TAIL_TYPE_DIGIT, TAIL_TYPE_VALUE, TAIL_DATA_DIGIT,
    TAIL_CK_DIGIT, TAIL_CK_VALUE, TAIL_LINE_END
  } tail_kind_e;

  typedef struct packed {
    kind_t   kind;
    addr_t   address;
    byte_t   data_byte;
    status_t status;
  } hex_word_t;

  class hex_record_board;
    parse_phase_e ph;
    bit           low_next;
    logic [3:0]   hi_nib;
    byte_t        rec_len;
    addr_t        base;
    bit           is_end;
    byte_t        left;
    byte_t        sum;
    bit           stopped;
    hex_word_t    awaited[$];
    int           errors;

    function new();
      ph       = PH_HUNT;
      low_next = 1'b0;
      hi_nib   = '0;
      rec_len  = '0;
      base     = '0;
      is_end   = 1'b0;
      left     = '0;
      sum      = '0;
      stopped  = 1'b0;
      errors   = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void push(kind_t k, addr_t a, byte_t d, status_t s);
      hex_word_t w;
      w.kind      = k;
      w.address   = a;
      w.data_byte = d;
      w.status    = s;
      awaited.push_back(w);
    endfunction

    function void abort(status_t s);
      stopped = 1'b1;
      ph      = PH_HUNT;
      push(KIND_DONE, '0, '0, s);
    endfunction

    function status_t field_error();
      case (ph)
        PH_LEN:                 return ST_LENGTH;
        PH_ADDR_HI, PH_ADDR_LO: return ST_ADDRESS;
        PH_TYPE:                return ST_TYPE;
        PH_DATA:                return ST_DATA;
        PH_CK:                  return ST_CK_MISS;
        default:                return ST_MISMATCH;
      endcase
    endfunction

    function int nibble_of(char_t c, bit eoi);
      if (eoi) return -1;
      if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;  // 0-9
      if (c >= 8'h41 && c <= 8'h46) return c - 8'h37;  // A-F
      if (c >= 8'h61 && c <= 8'h66) return c - 8'h57;  // a-f
      return -1;
    endfunction

    // parse one character word, queue the result it causes
    function void note_char(char_t c, bit eoi);
      int    nib;
      byte_t b;
      byte_t off;
      if (stopped) return;
      if (ph == PH_EOL || ph == PH_EOL_LF) begin
        if (!eoi && c == CHAR_LF) begin
          ph = PH_HUNT;
          if (is_end) begin
            stopped = 1'b1;
            push(KIND_DONE, '0, '0, ST_END);
          end else begin
            push(KIND_DONE, '0, '0, ST_OK);
          end
        end else if (!eoi && c == CHAR_CR && ph == PH_EOL) begin
          ph = PH_EOL_LF;
        end else begin
          abort(ST_NO_EOL);
        end
        return;
      end
      if (ph == PH_HUNT) begin
        if (eoi) return;
        if (c == CHAR_CR || c == CHAR_LF) begin
          push(KIND_BLANK, '0, '0, ST_OK);
        end else if (c == CHAR_COLON) begin
          ph       = PH_LEN;
          low_next = 1'b0;
          hi_nib   = '0;
          sum      = '0;
        end
        return;
      end
      nib = nibble_of(c, eoi);
      if (nib < 0) begin
        abort(field_error());
        return;
      end
      if (!low_next) begin
        hi_nib   = nib[3:0];
        low_next = 1'b1;
        return;
      end
      low_next = 1'b0;
      b        = {hi_nib, nib[3:0]};
      sum      = sum + b;
      case (ph)
        PH_LEN: begin
          rec_len = b;
          ph      = PH_ADDR_HI;
        end
        PH_ADDR_HI: begin
          base = {b, 8'h00};
          ph   = PH_ADDR_LO;
        end
        PH_ADDR_LO: begin
          base[7:0] = b;
          ph        = PH_TYPE;
        end
        PH_TYPE: begin
          if (b == 8'h00) begin
            is_end = 1'b0;
            left   = rec_len;
            ph     = (rec_len != 8'h00) ? PH_DATA : PH_CK;
          end else if (b == 8'h01) begin
            is_end = 1'b1;
            ph     = PH_END_CK;
          end else begin
            abort(ST_UNSUPP);
          end
        end
        PH_DATA: begin
          off  = rec_len - left;
          push(KIND_DATA, base + {8'h00, off}, b, ST_OK);
          left = left - 8'd1;
          if (left == 8'h00) ph = PH_CK;
        end
        PH_CK: begin
          if (sum != 8'h00) abort(ST_MISMATCH);
          else ph = PH_EOL;
        end
        default: begin
          if (b != END_CK) abort(ST_MISMATCH);
          else ph = PH_EOL;
        end
      endcase
    endfunction

    function void flag(string what, hex_word_t want, hex_word_t got);
      errors++;
      if (errors <= 10) begin
        $display("%0t %s: exp k=%0d a=%h d=%h s=%0d, got k=%0d a=%h d=%h s=%0d",
                 $realtime, what, want.kind, want.address, want.data_byte, want.status,
                 got.kind, got.address, got.data_byte, got.status);
      end
    endfunction

    function void check_word(hex_word_t got);
      hex_word_t want;
      if (awaited.size() == 0) begin
        flag("unexpected word", '0, got);
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind || got.address !== want.address ||
          got.data_byte !== want.data_byte || got.status !== want.status) begin
        flag("mismatch", want, got);
      end
    endfunction

    function void check_leftover();
      while (awaited.size() != 0) begin
        flag("missing word", awaited.pop_front(), '0);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   sent_count;
  int   in_calm;
  int   out_calm;

  hex_record_board board = new();

  ihex_in_if  in_ch();
  ihex_out_if out_ch();

  intel_hex_record_parser_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // idle draw with occasional stretches of back-to-back words
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic bit is_hex(char_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic char_t hex_digit(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    if ($urandom_range(0, 1)) return 8'h37 + {4'h0, v};
    return 8'h57 + {4'h0, v};
  endfunction

  task automatic send_char(input char_t c, input bit eoi);
    int idle;
    idle = draw_wait(in_calm);
    repeat (idle) @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.char_code    = c;
    in_ch.end_of_input = eoi;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_char(c, eoi);
    sent_count++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic put_byte(input byte_t b, inout byte_t ck);
    send_char(hex_digit(b[7:4]), 1'b0);
    send_char(hex_digit(b[3:0]), 1'b0);
    ck = ck + b;
  endtask

  // not a hex digit: stray character or end of input
  task automatic send_bad_digit();
    char_t c;
    if ($urandom_range(0, 3) == 0) begin
      send_char(char_t'($urandom_range(0, 255)), 1'b1);
    end else begin
      do c = char_t'($urandom_range(0, 255)); while (is_hex(c));
      send_char(c, 1'b0);
    end
  endtask

  task automatic send_broken_byte();
    if ($urandom_range(0, 1)) send_char(hex_digit(4'($urandom)), 1'b0);
    send_bad_digit();
  endtask

  task automatic send_line_end();
    if ($urandom_range(0, 1)) send_char(CHAR_CR, 1'b0);
    send_char(CHAR_LF, 1'b0);
  endtask

  task automatic send_header(input byte_t len, input addr_t a, input byte_t rtype,
                             inout byte_t ck);
    send_char(CHAR_COLON, 1'b0);
    put_byte(len, ck);
    put_byte(a[15:8], ck);
    put_byte(a[7:0], ck);
    put_byte(rtype, ck);
  endtask

  task automatic send_data_record(input addr_t a, input int n);
    byte_t ck;
    byte_t v;
    ck = 8'h00;
    send_header(byte_t'(n), a, 8'h00, ck);
    repeat (n) begin
      v = byte_t'($urandom);
      put_byte(v, ck);
    end
    v = ~ck + 8'd1;
    put_byte(v, ck);
    send_line_end();
  endtask

  task automatic send_noise();
    char_t c;
    if ($urandom_range(0, 4) == 0) begin
      send_char(char_t'($urandom_range(0, 255)), 1'b1);
    end else begin
      do c = char_t'($urandom_range(0, 255)); while (c == CHAR_COLON);
      send_char(c, 1'b0);
    end
  endtask

  // one record that ends the parse, by an end record or by an error
  task automatic send_tail(input tail_kind_e tk);
    byte_t ck;
    byte_t v;
    int    n;
    int    k;
    ck = 8'h00;
    n  = $urandom_range(1, 6);
    k  = $urandom_range(0, n - 1);
    case (tk)
      TAIL_END_OK, TAIL_END_CK_VALUE, TAIL_END_CK_DIGIT: begin
        // length and address of an end record carry no meaning
        send_header(byte_t'($urandom), addr_t'($urandom), 8'h01, ck);
        if (tk == TAIL_END_OK) begin
          put_byte(END_CK, ck);
          send_line_end();
        end else if (tk == TAIL_END_CK_VALUE) begin
          put_byte(byte_t'($urandom_range(0, 254)), ck);
        end else begin
          send_broken_byte();
        end
      end
      TAIL_LEN_DIGIT: begin
        send_char(CHAR_COLON, 1'b0);
        send_broken_byte();
      end
      TAIL_ADDR_DIGIT: begin
        send_char(CHAR_COLON, 1'b0);
        put_byte(byte_t'(n), ck);
        if ($urandom_range(0, 1)) put_byte(byte_t'($urandom), ck);
        send_broken_byte();
      end
      TAIL_TYPE_DIGIT: begin
        send_char(CHAR_COLON, 1'b0);
        put_byte(byte_t'(n), ck);
        put_byte(byte_t'($urandom), ck);
        put_byte(byte_t'($urandom), ck);
        send_broken_byte();
      end
      TAIL_TYPE_VALUE: begin
        send_header(byte_t'(n), addr_t'($urandom), byte_t'($urandom_range(2, 255)), ck);
      end
      TAIL_DATA_DIGIT: begin
        send_header(byte_t'(n), addr_t'($urandom), 8'h00, ck);
        repeat (k) put_byte(byte_t'($urandom), ck);
        send_broken_byte();
      end
      default: begin
        send_header(byte_t'(n), addr_t'($urandom), 8'h00, ck);
        repeat (n) put_byte(byte_t'($urandom), ck);
        if (tk == TAIL_CK_DIGIT) begin
          send_broken_byte();
        end else if (tk == TAIL_CK_VALUE) begin
          v = ~ck + 8'd1 + byte_t'($urandom_range(1, 255));
          put_byte(v, ck);
        end else begin
          v = ~ck + 8'd1;
          put_byte(v, ck);
          if ($urandom_range(0, 1)) send_char(CHAR_CR, 1'b0);
          if ($urandom_range(0, 2) == 0) begin
            send_char(char_t'($urandom_range(0, 255)), 1'b1);
          end else begin
            do v = byte_t'($urandom_range(0, 255)); while (v == CHAR_LF || v == CHAR_CR);
            send_char(v, 1'b0);
          end
        end
      end
    endcase
  endtask

  // receiver: random stall before each result word
  initial begin
    hex_word_t got;
    int        stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = draw_wait(out_calm);
      out_ch.ready = 1'b0;
      repeat (stall) @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.kind      = out_ch.kind;
      got.address   = out_ch.address;
      got.data_byte = out_ch.data_byte;
      got.status    = out_ch.status;
      board.check_word(got);
    end
  end

  initial begin
    int  r;
    int  guard;
    bit  drained;
    tail_kind_e tk;
    cycle_count        = 0;
    sent_count         = 0;
    in_calm            = 0;
    out_calm           = 0;
    drained            = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.char_code    = '0;
    in_ch.end_of_input = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: char extremes, end of input while idle, blank lines, empty record
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CHAR_COLON, 1'b1);
    send_char(8'h20, 1'b0);
    send_char(CHAR_CR, 1'b0);
    send_char(CHAR_LF, 1'b0);
    send_data_record(16'h0000, 0);

    // record that wraps past the top of the address space
    send_data_record(addr_t'($urandom_range(16'hFFE8, 16'hFFFF)), 32);

    while (sent_count < RANDOM_CHARS) begin
      if (!drained && sent_count > RANDOM_CHARS / 2) begin
        while (board.pending() != 0) @(negedge clk);
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_data_record(addr_t'($urandom), ($urandom_range(0, 3) == 0) ?
                         $urandom_range(0, 2) : $urandom_range(1, 16));
      end else if (r < 75) begin
        repeat ($urandom_range(1, 4)) send_noise();
      end else if (r < 90) begin
        send_line_end();
      end else begin
        repeat ($urandom_range(1, 3)) send_char($urandom_range(0, 1) ? 8'h20 : 8'h09, 1'b0);
      end
    end

    tk = tail_kind_e'($urandom_range(TAIL_END_OK, TAIL_LINE_END));
    send_tail(tk);

    // parser is halted now: nothing below may produce a word
    repeat (10) send_noise();
    send_data_record(addr_t'($urandom), $urandom_range(1, 4));
    send_line_end();

    guard = 0;
    while (board.pending() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    board.check_leftover();
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ihex_pkg.sv
rtl/core/ihex_if.sv
rtl/core/intel_hex_record_parser_unit.sv
sim/tb_intel_hex_record_parser_unit.sv
